>>> rtl/core/uidrr_pkg.sv
// shared types and codes for the unique-id round-robin queue
package uidrr_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int CAP_RESET     = 64;
  localparam int ID_W          = 16;
  localparam int CMD_W         = 3;
  localparam int STATUS_W      = 3;
  localparam int POS_W         = 6;
  localparam int CFG_W         = 7;
  localparam int OCC_W         = 7;

  localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ENQUEUE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ROTATE   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_READ_POS = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ_HD  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd5;
  localparam logic [CMD_W-1:0] CMD_FIND     = 3'd6;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_SHIFT,
    S_EMIT
  } state_t;

endpackage

>>> rtl/core/uidrr_ram.sv
// generic single-write, single-read ram with registered read data
module uidrr_ram #(
  parameter int WIDTH = uidrr_pkg::ID_W,
  parameter int DEPTH = uidrr_pkg::DEPTH_DEFAULT,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/unique_id_round_robin_queue_unit.sv
// unique-id round-robin ready queue: command sequencer around the ring ram
// clear, failed and empty-queue commands go straight to the result; reads and rotate take one ram read first;
//   enqueue, find and remove scan from the head, one ram read per cycle
// remove with gap closing then moves each later entry one slot toward the head and steps the tail back
// one command at a time, set by the single ram port pair
// synchronous reset empties the queue and sets capacity to min(64, DEPTH); ring ram not cleared
module unique_id_round_robin_queue_unit #(
  parameter int DEPTH = uidrr_pkg::DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [uidrr_pkg::CFG_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [uidrr_pkg::CMD_W-1:0]   cmd,
  input  logic [uidrr_pkg::ID_W-1:0]    ident,
  input  logic [uidrr_pkg::POS_W-1:0]   position,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [uidrr_pkg::STATUS_W-1:0] status,
  output logic [uidrr_pkg::ID_W-1:0]    value,
  output logic [uidrr_pkg::OCC_W-1:0]   occupancy
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = ((CW > uidrr_pkg::CFG_W) ? CW : uidrr_pkg::CFG_W) + 1;
  localparam int OW = uidrr_pkg::OCC_W;

  uidrr_pkg::state_t state, state_next;

  logic [AW-1:0] head, head_next;
  logic [AW-1:0] tail, tail_next;
  logic [CW-1:0] entry_count, entry_count_next;
  logic [CW-1:0] cap, cap_next;

  logic [uidrr_pkg::CMD_W-1:0]    cmd_r, cmd_r_next;
  logic [uidrr_pkg::ID_W-1:0]     id_r, id_r_next;
  logic [uidrr_pkg::STATUS_W-1:0] status_r, status_r_next;
  logic [uidrr_pkg::ID_W-1:0]     value_r, value_r_next;

  // scan pipeline: issue stage and compare stage
  logic [AW-1:0] iss_ptr, iss_ptr_next;
  logic [CW-1:0] iss_j, iss_j_next;
  logic          cmp_valid, cmp_valid_next;
  logic [AW-1:0] cmp_ptr, cmp_ptr_next;
  logic [CW-1:0] cmp_j, cmp_j_next;

  // gap closing: read ahead, write one behind
  logic [AW-1:0] sh_rd, sh_rd_next;
  logic [AW-1:0] sh_wr, sh_wr_next;
  logic [CW-1:0] sh_left, sh_left_next;
  logic          sh_pend, sh_pend_next;

  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [uidrr_pkg::ID_W-1:0] ram_wdata;
  logic [AW-1:0]              ram_raddr;
  logic [uidrr_pkg::ID_W-1:0] ram_rdata;

  logic [SW-1:0]      pos_sum;
  logic [AW-1:0]      pos_slot;
  logic               cfg_above;
  logic               match;
  logic               last;
  logic [CW+OW-1:0]   occ_wide;

  function automatic logic [AW-1:0] adv(input logic [AW-1:0] i, input logic [CW-1:0] c);
    logic [CW-1:0] n;
    n = CW'(i) + CW'(1);
    return (n >= c) ? '0 : AW'(n);
  endfunction

  uidrr_ram #(
    .WIDTH(uidrr_pkg::ID_W),
    .DEPTH(DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_stall = (state != uidrr_pkg::S_IDLE);
  assign occ_wide = {{OW{1'b0}}, entry_count};

  // slot of an offset from the head, one wrap at most
  always_comb begin
    pos_sum = SW'(head) + SW'(position);
    if (pos_sum >= SW'(cap)) begin
      pos_sum = pos_sum - SW'(cap);
    end
    pos_slot = AW'(pos_sum);
  end

  assign cfg_above = (SW'(cfg_data) > SW'(DEPTH));
  assign match = cmp_valid && (ram_rdata == id_r);
  assign last  = cmp_valid && (cmp_j == entry_count - CW'(1));

  always_comb begin
    state_next       = state;
    head_next        = head;
    tail_next        = tail;
    entry_count_next = entry_count;
    cap_next         = cap;
    cmd_r_next       = cmd_r;
    id_r_next        = id_r;
    status_r_next    = status_r;
    value_r_next     = value_r;
    iss_ptr_next     = iss_ptr;
    iss_j_next       = iss_j;
    cmp_valid_next   = 1'b0;
    cmp_ptr_next     = cmp_ptr;
    cmp_j_next       = cmp_j;
    sh_rd_next       = sh_rd;
    sh_wr_next       = sh_wr;
    sh_left_next     = sh_left;
    sh_pend_next     = 1'b0;
    ram_we           = 1'b0;
    ram_waddr        = tail;
    ram_wdata        = id_r;
    ram_raddr        = head;

    case (state)
      uidrr_pkg::S_IDLE: begin
        if (cmd == uidrr_pkg::CMD_READ_POS) begin
          ram_raddr = pos_slot;
        end
        if (in_valid) begin
          cmd_r_next    = cmd;
          id_r_next     = ident;
          status_r_next = uidrr_pkg::ST_OK;
          value_r_next  = '0;
          iss_ptr_next  = head;
          iss_j_next    = '0;
          state_next    = uidrr_pkg::S_EMIT;
          case (cmd)
            uidrr_pkg::CMD_CLEAR: begin
              head_next        = '0;
              tail_next        = '0;
              entry_count_next = '0;
            end
            uidrr_pkg::CMD_ENQUEUE: begin
              if (entry_count == '0) begin
                ram_we           = 1'b1;
                ram_waddr        = tail;
                ram_wdata        = ident;
                tail_next        = adv(tail, cap);
                entry_count_next = entry_count + CW'(1);
              end else begin
                state_next = uidrr_pkg::S_SCAN;
              end
            end
            uidrr_pkg::CMD_ROTATE, uidrr_pkg::CMD_READ_HD: begin
              if (entry_count == '0) begin
                status_r_next = uidrr_pkg::ST_EMPTY;
              end else begin
                state_next = uidrr_pkg::S_READ;
              end
            end
            uidrr_pkg::CMD_READ_POS: begin
              if (SW'(position) >= SW'(entry_count)) begin
                status_r_next = uidrr_pkg::ST_NOT_FOUND;
              end else begin
                state_next = uidrr_pkg::S_READ;
              end
            end
            uidrr_pkg::CMD_REMOVE, uidrr_pkg::CMD_FIND: begin
              if (entry_count == '0) begin
                status_r_next = uidrr_pkg::ST_NOT_FOUND;
              end else begin
                state_next = uidrr_pkg::S_SCAN;
              end
            end
            default: begin
              status_r_next = uidrr_pkg::ST_NOT_FOUND;
            end
          endcase
        end else if (cfg_write && (entry_count == '0)) begin
          if (cfg_data == '0) begin
            cap_next = CW'(1);
          end else if (cfg_above) begin
            cap_next = CW'(DEPTH);
          end else begin
            cap_next = CW'(cfg_data);
          end
          head_next = '0;
          tail_next = '0;
        end
      end

      uidrr_pkg::S_READ: begin
        value_r_next = ram_rdata;
        if (cmd_r == uidrr_pkg::CMD_ROTATE) begin
          ram_we    = 1'b1;
          ram_waddr = tail;
          ram_wdata = ram_rdata;
          head_next = adv(head, cap);
          tail_next = adv(tail, cap);
        end
        state_next = uidrr_pkg::S_EMIT;
      end

      uidrr_pkg::S_SCAN: begin
        ram_raddr = iss_ptr;
        if (iss_j < entry_count) begin
          iss_ptr_next   = adv(iss_ptr, cap);
          iss_j_next     = iss_j + CW'(1);
          cmp_valid_next = 1'b1;
          cmp_ptr_next   = iss_ptr;
          cmp_j_next     = iss_j;
        end
        if (match || last) begin
          cmp_valid_next = 1'b0;
          state_next     = uidrr_pkg::S_EMIT;
          case (cmd_r)
            uidrr_pkg::CMD_ENQUEUE: begin
              if (match) begin
                status_r_next = uidrr_pkg::ST_PRESENT;
              end else if (entry_count >= cap) begin
                status_r_next = uidrr_pkg::ST_FULL;
              end else begin
                ram_we           = 1'b1;
                ram_waddr        = tail;
                ram_wdata        = id_r;
                tail_next        = adv(tail, cap);
                entry_count_next = entry_count + CW'(1);
              end
            end
            uidrr_pkg::CMD_REMOVE: begin
              if (!match) begin
                status_r_next = uidrr_pkg::ST_NOT_FOUND;
              end else if (cmp_j == '0) begin
                head_next        = adv(head, cap);
                entry_count_next = entry_count - CW'(1);
              end else begin
                sh_wr_next   = cmp_ptr;
                sh_rd_next   = adv(cmp_ptr, cap);
                sh_left_next = entry_count - cmp_j - CW'(1);
                state_next   = uidrr_pkg::S_SHIFT;
              end
            end
            default: begin
              if (!match) begin
                status_r_next = uidrr_pkg::ST_NOT_FOUND;
              end
            end
          endcase
        end
      end

      uidrr_pkg::S_SHIFT: begin
        ram_raddr = sh_rd;
        if (sh_left != '0) begin
          sh_rd_next   = adv(sh_rd, cap);
          sh_left_next = sh_left - CW'(1);
          sh_pend_next = 1'b1;
        end
        if (sh_pend) begin
          ram_we     = 1'b1;
          ram_waddr  = sh_wr;
          ram_wdata  = ram_rdata;
          sh_wr_next = adv(sh_wr, cap);
        end
        if ((sh_left == '0) && !sh_pend) begin
          entry_count_next = entry_count - CW'(1);
          tail_next        = (tail == '0) ? AW'(cap - CW'(1)) : tail - AW'(1);
          state_next       = uidrr_pkg::S_EMIT;
        end
      end

      uidrr_pkg::S_EMIT: begin
        if (!out_valid || !out_stall) begin
          state_next = uidrr_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = uidrr_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= uidrr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head        <= '0;
      tail        <= '0;
      entry_count <= '0;
      cap         <= CW'((DEPTH < uidrr_pkg::CAP_RESET) ? DEPTH : uidrr_pkg::CAP_RESET);
      cmp_valid   <= 1'b0;
      sh_pend     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      head        <= head_next;
      tail        <= tail_next;
      entry_count <= entry_count_next;
      cap         <= cap_next;
      cmp_valid   <= cmp_valid_next;
      sh_pend     <= sh_pend_next;
      if (state == uidrr_pkg::S_EMIT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_r_next;
    id_r     <= id_r_next;
    status_r <= status_r_next;
    value_r  <= value_r_next;
    iss_ptr  <= iss_ptr_next;
    iss_j    <= iss_j_next;
    cmp_ptr  <= cmp_ptr_next;
    cmp_j    <= cmp_j_next;
    sh_rd    <= sh_rd_next;
    sh_wr    <= sh_wr_next;
    sh_left  <= sh_left_next;
    if (state == uidrr_pkg::S_EMIT && (!out_valid || !out_stall)) begin
      status    <= status_r;
      value     <= value_r;
      occupancy <= occ_wide[OW-1:0];
    end
  end

  // count never exceeds the ring size in use
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    entry_count <= cap)
    else $error("entry count above capacity");

  // ring pointers stay inside the capacity
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (CW'(head) < cap) && (CW'(tail) < cap))
    else $error("ring pointer outside capacity");

  // empty ring has head and tail together
  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    (entry_count == '0) |-> (head == tail))
    else $error("empty queue with head and tail apart");

  // an accepted request always leaves idle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state != uidrr_pkg::S_IDLE))
    else $error("request accepted without starting work");

endmodule
